// File: rtl/bpc_pkg.sv
// Shared types and constants for the button press classifier.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

    // Widths fixed by the item format.
    localparam int MAX_BUTTONS   = 4;
    localparam int TIME_W        = 32;
    localparam int CFG_W         = 16;
    localparam int STATUS_W      = 3;
    localparam int STATUS_WORD_W = MAX_BUTTONS * STATUS_W;
    localparam int CFG_INDEX_W   = 1;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd20;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS = 1'd1;

    // Reported status codes, one per button.
    localparam logic [STATUS_W-1:0] STATUS_IDLE      = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_DEBOUNCE  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_PRESSED   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_RELEASED  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_LONG      = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_HOLDING   = 3'd5;
    localparam logic [STATUS_W-1:0] STATUS_LONGLONG  = 3'd6;

    // Timing settings shared by every lane.
    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
    } timing_cfg_t;

    // Per-poll control that each lane receives.
    typedef struct packed {
        logic              accept;
        logic [TIME_W-1:0] now_ms;
    } poll_ctrl_t;

    typedef logic [MAX_BUTTONS-1:0][STATUS_W-1:0] report_vec_t;

endpackage

`default_nettype wire

// File: rtl/bpc_if.sv
// Valid/ready channel interfaces for the button press classifier.
// Depends on bpc_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface bpc_poll_if;
    logic                                   valid;
    logic                                   ready;
    logic [bpc_pkg::TIME_W-1:0]             now_ms;
    logic [bpc_pkg::MAX_BUTTONS-1:0]        pin_levels;

    modport source (output valid, output now_ms, output pin_levels, input ready);
    modport sink   (input valid, input now_ms, input pin_levels, output ready);
endinterface

interface bpc_status_if;
    logic                                   valid;
    logic                                   ready;
    logic [bpc_pkg::STATUS_WORD_W-1:0]      status_word;

    modport source (output valid, output status_word, input ready);
    modport sink   (input valid, input status_word, output ready);
endinterface

`default_nettype wire

// File: rtl/bpc_lane.sv
// One button lane: stored phase and event time, update and poll phases folded together.
// Depends on bpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpc_lane (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire bpc_pkg::poll_ctrl_t            ctrl,
    input  wire logic                           pin_level,
    input  wire bpc_pkg::timing_cfg_t           timing,
    output logic [bpc_pkg::STATUS_W-1:0]        report
);

    typedef enum logic [2:0] {
        S_IDLE     = 3'd0,
        S_DEBOUNCE = 3'd1,
        S_PRESSED  = 3'd2,
        S_RELEASED = 3'd3,
        S_LONG     = 3'd4,
        S_HOLDING  = 3'd5
    } state_t;

    state_t                         state_reg, state_next;
    logic [bpc_pkg::TIME_W-1:0]     event_time_reg, event_time_next;
    logic [bpc_pkg::TIME_W-1:0]     elapsed;
    logic                           down;
    logic                           debounce_done;
    logic                           long_done;
    logic                           long_zero;

    // Time since the last event, modulo 2^32, and the two threshold checks.
    assign down          = ~pin_level;
    assign elapsed       = ctrl.now_ms - event_time_reg;
    assign debounce_done = elapsed >= {{(bpc_pkg::TIME_W-bpc_pkg::CFG_W){1'b0}},
                                       timing.debounce_ms};
    assign long_done     = elapsed >= {{(bpc_pkg::TIME_W-bpc_pkg::CFG_W){1'b0}},
                                       timing.long_press_ms};
    assign long_zero     = timing.long_press_ms == '0;

    // Update phase folded together with the consuming poll phase.
    always_comb
    begin
        state_next      = state_reg;
        event_time_next = event_time_reg;
        report          = bpc_pkg::STATUS_IDLE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (down)
                begin
                    event_time_next = ctrl.now_ms;
                    state_next      = S_DEBOUNCE;
                    report          = bpc_pkg::STATUS_DEBOUNCE;
                end
            end
            S_DEBOUNCE:
            begin
                report = bpc_pkg::STATUS_DEBOUNCE;
                if (debounce_done)
                begin
                    state_next = S_PRESSED;
                    report     = bpc_pkg::STATUS_PRESSED;
                end
            end
            S_PRESSED:
            begin
                report = bpc_pkg::STATUS_PRESSED;
                if (!down)
                begin
                    // Release is reported once and consumed straight away.
                    state_next = S_IDLE;
                    report     = bpc_pkg::STATUS_RELEASED;
                end
                else if (long_done)
                begin
                    event_time_next = ctrl.now_ms;
                    if (long_zero)
                    begin
                        // With no long-press time the poll fires a long-long press at once.
                        state_next = S_LONG;
                        report     = bpc_pkg::STATUS_LONGLONG;
                    end
                    else
                    begin
                        state_next = S_HOLDING;
                        report     = bpc_pkg::STATUS_LONG;
                    end
                end
            end
            S_RELEASED:
            begin
                state_next = S_IDLE;
                report     = bpc_pkg::STATUS_RELEASED;
            end
            default:
            begin
                // Long press and holding: consumed, held, or repeated.
                report = (state_reg == S_LONG) ? bpc_pkg::STATUS_LONG
                                               : bpc_pkg::STATUS_HOLDING;
                if (!down)
                begin
                    state_next = S_IDLE;
                end
                else if (!long_done)
                begin
                    state_next = S_HOLDING;
                end
                else
                begin
                    event_time_next = ctrl.now_ms;
                    report          = bpc_pkg::STATUS_LONGLONG;
                end
            end
        endcase
    end

    // Lane state advances only when a poll item is accepted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            event_time_reg <= '0;
        end
        else if (ctrl.accept)
        begin
            state_reg      <= state_next;
            event_time_reg <= event_time_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/bpc_merge.sv
// Merging stage: packs the lane reports into one status word and holds it for the sink.
// Depends on bpc_pkg and bpc_if.
`timescale 1ns / 1ps
`default_nettype none

module bpc_merge (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   poll_valid,
    output logic                        poll_ready,
    input  wire bpc_pkg::report_vec_t   reports,
    bpc_status_if.source                status_ch
);

    logic                                   out_valid_reg, out_valid_next;
    logic [bpc_pkg::STATUS_WORD_W-1:0]      word_reg, word_next;
    logic                                   load;

    // A new item may enter whenever the output slot is empty or being drained.
    assign poll_ready = !out_valid_reg || status_ch.ready;
    assign load       = poll_valid && poll_ready;

    // Pack button i into bits 3i+2..3i.
    always_comb
    begin
        word_next = '0;
        for (int i = 0; i < bpc_pkg::MAX_BUTTONS; i++)
        begin
            word_next[i*bpc_pkg::STATUS_W +: bpc_pkg::STATUS_W] = reports[i];
        end
        out_valid_next = load || (out_valid_reg && !status_ch.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload register, loaded with each accepted item.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
        end
    end

    assign status_ch.valid       = out_valid_reg;
    assign status_ch.status_word = word_reg;

endmodule

`default_nettype wire

// File: rtl/button_press_classifier_unit.sv
// Top level of the button press classifier: config registers, button lanes, merging stage.
// Depends on bpc_pkg, bpc_if, bpc_lane and bpc_merge.
//
// Usage:
//   poll_ch carries one poll item: now_ms (32-bit millisecond time) and pin_levels
//   (bit i low means button i is pressed). status_ch returns one item per poll:
//   status_word with three bits per button (idle, debouncing, pressed, released,
//   long press, holding, long-long press). Buttons at NUM_BUTTONS and above read 0.
//   The configuration port (cfg_we, cfg_index, cfg_data) sets debounce_ms (index 0)
//   and long_press_ms (index 1); write it only while no poll is in flight.
//   An item accepted on poll_ch is offered on status_ch from the next cycle.
//   Throughput is one item per cycle while the receiver keeps taking items; every
//   lane handles its button's whole update and poll beside the others.
//   A single output register sits between the lanes and status_ch; while the
//   receiver stalls, the item is held there and poll_ch.ready is low unless the
//   held item is taken in the same cycle.
//   Reset puts every button in idle with a zero event time, debounce_ms to 20
//   and long_press_ms to 1000, and leaves the output empty.
`timescale 1ns / 1ps
`default_nettype none

module button_press_classifier_unit #(
    parameter int NUM_BUTTONS = 4
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    bpc_poll_if.sink                                poll_ch,
    bpc_status_if.source                            status_ch,
    input  wire logic                               cfg_we,
    input  wire logic [bpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [bpc_pkg::CFG_W-1:0]          cfg_data
);

    localparam logic [bpc_pkg::STATUS_WORD_W-1:0] USED_MASK =
        bpc_pkg::STATUS_WORD_W'((64'd1 << (NUM_BUTTONS * bpc_pkg::STATUS_W)) - 64'd1);

    bpc_pkg::timing_cfg_t   timing_reg;
    bpc_pkg::poll_ctrl_t    ctrl;
    bpc_pkg::report_vec_t   reports;
    logic                   poll_ready;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.debounce_ms   <= bpc_pkg::DEBOUNCE_RESET;
            timing_reg.long_press_ms <= bpc_pkg::LONG_PRESS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bpc_pkg::CFG_DEBOUNCE:   timing_reg.debounce_ms   <= cfg_data;
                bpc_pkg::CFG_LONG_PRESS: timing_reg.long_press_ms <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // Handshake of the poll channel.
    assign poll_ch.ready = poll_ready;
    assign ctrl.accept   = poll_ch.valid && poll_ready;
    assign ctrl.now_ms   = poll_ch.now_ms;

    // One lane per button; lanes beyond NUM_BUTTONS report idle.
    for (genvar g = 0; g < bpc_pkg::MAX_BUTTONS; g++)
    begin : g_lane
        if (g < NUM_BUTTONS)
        begin : g_used
            bpc_lane u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .pin_level (poll_ch.pin_levels[g]),
                .timing    (timing_reg),
                .report    (reports[g])
            );
        end
        else
        begin : g_unused
            assign reports[g] = bpc_pkg::STATUS_IDLE;
        end
    end

    // Merging stage and output register.
    bpc_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .poll_valid (poll_ch.valid),
        .poll_ready (poll_ready),
        .reports    (reports),
        .status_ch  (status_ch)
    );

`ifndef SYNTHESIS
    // Every accepted poll produces a result item in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (poll_ch.valid && poll_ch.ready) |=> status_ch.valid)
        else $error("accepted poll item gave no result item");

    // Buttons that are not fitted always read idle.
    a_unused_idle: assert property (@(posedge clk) disable iff (!rst_n)
        status_ch.valid |-> ((status_ch.status_word & ~USED_MASK) == '0))
        else $error("status bits of an unused button are not idle");

    // No button ever reports the undefined code seven.
    a_no_code_seven: assert property (@(posedge clk) disable iff (!rst_n)
        status_ch.valid |-> (status_ch.status_word[2:0] != 3'd7 &&
                             status_ch.status_word[5:3] != 3'd7 &&
                             status_ch.status_word[8:6] != 3'd7 &&
                             status_ch.status_word[11:9] != 3'd7))
        else $error("a button reported an undefined status code");
`endif

endmodule

`default_nettype wire
